/* hdl/epfmm_pkg.sv */
// ---------------------------------------------------------------------------
// epfmm_pkg
// Shared types and constants of the EMS page-frame memory mapper.
// ---------------------------------------------------------------------------
package epfmm_pkg;

   // page map geometry
   localparam int unsigned MAP_PAGES  = 512;
   localparam int unsigned MAP_AW     = 9;
   localparam int unsigned PAGE_SHIFT = 11;
   localparam int unsigned CODE_W     = 3;
   localparam logic [MAP_AW-1:0] CONV_PAGES = 9'd320;

   // region codes
   localparam logic [CODE_W-1:0] RG_UNUSED  = 3'd0;
   localparam logic [CODE_W-1:0] RG_RAM     = 3'd1;
   localparam logic [CODE_W-1:0] RG_BOOTROM = 3'd2;
   localparam logic [CODE_W-1:0] RG_SDCARD  = 3'd3;
   localparam logic [CODE_W-1:0] RG_EMS     = 3'd4;

   // item modes
   localparam logic [1:0] MODE_IO_RD   = 2'd0;
   localparam logic [1:0] MODE_IO_WR   = 2'd1;
   localparam logic [1:0] MODE_LOOKUP  = 2'd2;
   localparam logic [1:0] MODE_REBUILD = 2'd3;

   // port offsets from the port base
   localparam logic [15:0] OFS_FP_FIRST = 16'd0;
   localparam logic [15:0] OFS_FP_LAST  = 16'd7;
   localparam logic [15:0] OFS_EMS_LO   = 16'd10;
   localparam logic [15:0] OFS_EMS_HI   = 16'd11;
   localparam logic [15:0] OFS_EMS_FILL = 16'd12;
   localparam logic [15:0] OFS_UMB_LO   = 16'd13;
   localparam logic [15:0] OFS_UMB_HI   = 16'd14;
   localparam logic [15:0] OFS_UMB_FILL = 16'd15;

   // CSR indices
   localparam logic [7:0] CSR_NO_CONV   = 8'd0;
   localparam logic [7:0] CSR_NO_BOOT   = 8'd1;
   localparam logic [7:0] CSR_BOOT_ADDR = 8'd2;
   localparam logic [7:0] CSR_BOOT_SIZE = 8'd3;

   // reset values
   localparam logic [19:0] BOOT_ADDR_RST = 20'hF0000;
   localparam logic [20:0] BOOT_SIZE_RST = 21'h08000;
   localparam logic [15:0] FP_RST        = 16'hFFFF;
   localparam logic [MAP_AW-1:0] BLD_FIRST_RST = BOOT_ADDR_RST[19:11];
   localparam logic [10:0] BLD_LAST_RST =
      11'((22'(BOOT_ADDR_RST) + 22'(BOOT_SIZE_RST)) >> PAGE_SHIFT);

   // segment window for fills, EMS frame geometry
   localparam logic [18:0] SEG_LOW       = 19'h0A000;
   localparam logic [18:0] SEG_HIGH      = 19'h0F000;
   localparam logic [19:0] FRAME_MASK    = 20'hFC000;
   localparam logic [19:0] FRAME_OFS_MAX = 20'h0C000;
   localparam logic [7:0]  BYTE_NONE     = 8'hFF;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] io_port;
      logic [7:0]  write_data;
      logic [19:0] mem_address;
   } req_type;

   typedef struct packed {
      logic [7:0]        read_data;
      logic [CODE_W-1:0] region;
      logic              ems_hit;
      logic [29:0]       ems_address;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [MAP_AW-1:0] addr;
      logic [CODE_W-1:0] data;
   } map_wr_type;

endpackage

/* hdl/epfmm_page_ram.sv */
// ---------------------------------------------------------------------------
// epfmm_page_ram
// Page map store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module epfmm_page_ram (
   input  logic                                    clock,
   input  epfmm_pkg::map_wr_type                   wr,
   input  logic [epfmm_pkg::MAP_AW-1:0]            rd_addr,
   output logic [epfmm_pkg::CODE_W-1:0]            rd_data
);

   logic [epfmm_pkg::CODE_W-1:0] mem [epfmm_pkg::MAP_PAGES];
   logic [epfmm_pkg::CODE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/ems_page_frame_memory_mapper_unit.sv */
// Steps (accept to result valid): frame pointer and segment port beats go straight to
// ST_PUSH; lookups and the map read port pass ST_LOOK (one page map read) first; block
// fills sweep ST_FILL over the N pages written; a rebuild beat sweeps ST_BUILD, one map
// page per cycle. One item in flight at a time; the next beat is taken once the core
// is back in idle, even while the result waits on rsp_ready.
// Reset: synchronous; after reset all 512 map pages are rebuilt with req_ready low.
// ---------------------------------------------------------------------------
// ems_page_frame_memory_mapper_unit
// EMS page-frame mapper: 512-page region map, four EMS frame pointers,
// EMS/UMB base segments, I/O port decode and memory address lookup.
// ---------------------------------------------------------------------------
module ems_page_frame_memory_mapper_unit #(
   parameter int unsigned PORT_BASE = 608
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  epfmm_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output epfmm_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam logic [15:0] PORT_BASE_W = 16'(PORT_BASE);
   localparam int unsigned AW = epfmm_pkg::MAP_AW;
   localparam int unsigned CW = epfmm_pkg::CODE_W;

   // one-hot sequencer
   typedef enum logic [4:0] {
      ST_BUILD = 5'b00001,   // map sweep (reset or rebuild beat)
      ST_IDLE  = 5'b00010,   // waiting for a request beat
      ST_LOOK  = 5'b00100,   // map read data returns
      ST_FILL  = 5'b01000,   // block fill sweep
      ST_PUSH  = 5'b10000    // hand result to the output register
   } state_type;

   state_type state_ff, state_in;

   // architectural state
   logic [15:0] fp_ff [4];
   logic [15:0] fp_in [4];
   logic [15:0] ems_seg_ff, ems_seg_in;
   logic [15:0] umb_seg_ff, umb_seg_in;

   // configuration
   logic        ncm_ff, nbr_ff;
   logic [19:0] boot_addr_ff;
   logic [20:0] boot_size_ff;

   // map build sweep: config snapshot taken when the sweep starts
   logic          bld_ncm_ff, bld_ncm_in;
   logic          bld_nbr_ff, bld_nbr_in;
   logic [AW-1:0] bld_first_ff, bld_first_in;
   logic [10:0]   bld_last_ff, bld_last_in;
   logic [AW-1:0] bld_idx_ff, bld_idx_in;
   logic          bld_item_ff, bld_item_in;

   // fill sweep
   logic [AW:0]   fill_idx_ff, fill_idx_in;
   logic [10:0]   fill_left_ff, fill_left_in;
   logic [CW-1:0] fill_code_ff, fill_code_in;

   logic          look_io_ff, look_io_in;
   epfmm_pkg::rsp_type res_ff, res_in;
   epfmm_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // page map
   epfmm_pkg::map_wr_type map_wr;
   logic [AW-1:0] map_rd_addr;
   logic [CW-1:0] map_rd_data;

   epfmm_page_ram u_page_ram (
      .clock   (clock),
      .wr      (map_wr),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   // request decode
   logic        req_fire;
   logic        in_range;
   logic [15:0] port_ofs;
   logic [15:0] fp_sel;
   logic [18:0] ems_end, umb_end;
   logic        ems_fill_ok, umb_fill_ok;
   logic [21:0] boot_end;

   // lookup translation
   logic [19:0] frame_page, ems_base, frame_ofs;
   logic        frame_hit;

   // build code for the page under the sweep
   logic [10:0]   bld_idx_wide;
   logic [CW-1:0] bld_code;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign in_range = (req_data.io_port >= PORT_BASE_W);
   assign port_ofs = req_data.io_port - PORT_BASE_W;
   assign fp_sel   = fp_ff[port_ofs[2:1]];

   // fill bounds: base must sit in the upper memory window and the fill must end by 0xF000
   assign ems_end     = 19'(ems_seg_ff) + {1'b0, req_data.write_data, 10'd0};
   assign umb_end     = 19'(umb_seg_ff) + {4'd0, req_data.write_data, 7'd0};
   assign ems_fill_ok = (19'(ems_seg_ff) >= epfmm_pkg::SEG_LOW) &&
                        (ems_end <= epfmm_pkg::SEG_HIGH);
   assign umb_fill_ok = (19'(umb_seg_ff) >= epfmm_pkg::SEG_LOW) &&
                        (umb_end <= epfmm_pkg::SEG_HIGH);

   assign boot_end = 22'(boot_addr_ff) + 22'(boot_size_ff);

   // a frame hits only on an exact 16 KiB step of 0..3 frames above the EMS base
   assign frame_page = req_data.mem_address & epfmm_pkg::FRAME_MASK;
   assign ems_base   = {ems_seg_ff, 4'd0};
   assign frame_ofs  = frame_page - ems_base;
   assign frame_hit  = (frame_page >= ems_base) && (frame_ofs[13:0] == 14'd0) &&
                       (frame_ofs <= epfmm_pkg::FRAME_OFS_MAX);

   // boot ROM wins over RAM, SD page sits just past the ROM end
   assign bld_idx_wide = {2'd0, bld_idx_ff};
   always_comb begin
      if (!bld_nbr_ff && (bld_idx_wide >= {2'd0, bld_first_ff}) &&
          (bld_idx_wide < bld_last_ff)) begin
         bld_code = epfmm_pkg::RG_BOOTROM;
      end else if (!bld_nbr_ff && (bld_idx_wide == bld_last_ff)) begin
         bld_code = epfmm_pkg::RG_SDCARD;
      end else if (!bld_ncm_ff && (bld_idx_ff < epfmm_pkg::CONV_PAGES)) begin
         bld_code = epfmm_pkg::RG_RAM;
      end else begin
         bld_code = epfmm_pkg::RG_UNUSED;
      end
   end

   // map ports
   always_comb begin
      map_wr.en   = 1'b0;
      map_wr.addr = bld_idx_ff;
      map_wr.data = bld_code;
      if (state_ff == ST_BUILD) begin
         map_wr.en = 1'b1;
      end else if (state_ff == ST_FILL) begin
         map_wr.en   = (fill_left_ff != 11'd0) && !fill_idx_ff[AW];
         map_wr.addr = fill_idx_ff[AW-1:0];
         map_wr.data = fill_code_ff;
      end
   end

   // lookups read the page of the address, the map read port reads the UMB base page
   assign map_rd_addr = (req_data.mode == epfmm_pkg::MODE_LOOKUP) ?
                        req_data.mem_address[19:11] : umb_seg_ff[15:7];

   // sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      fp_in        = fp_ff;
      ems_seg_in   = ems_seg_ff;
      umb_seg_in   = umb_seg_ff;
      bld_ncm_in   = bld_ncm_ff;
      bld_nbr_in   = bld_nbr_ff;
      bld_first_in = bld_first_ff;
      bld_last_in  = bld_last_ff;
      bld_idx_in   = bld_idx_ff;
      bld_item_in  = bld_item_ff;
      fill_idx_in  = fill_idx_ff;
      fill_left_in = fill_left_ff;
      fill_code_in = fill_code_ff;
      look_io_in   = look_io_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_BUILD: begin
            bld_idx_in = bld_idx_ff + 1'b1;
            if (&bld_idx_ff) begin
               state_in = bld_item_ff ? ST_PUSH : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               res_in     = '0;
               look_io_in = 1'b0;
               state_in   = ST_PUSH;
               unique case (req_data.mode)
                  epfmm_pkg::MODE_IO_RD: begin
                     res_in.read_data = epfmm_pkg::BYTE_NONE;
                     if (in_range && (port_ofs <= epfmm_pkg::OFS_FP_LAST)) begin
                        res_in.read_data = port_ofs[0] ? fp_sel[15:8] : fp_sel[7:0];
                     end else if (in_range && (port_ofs == epfmm_pkg::OFS_UMB_FILL)) begin
                        look_io_in = 1'b1;
                        state_in   = ST_LOOK;
                     end
                  end
                  epfmm_pkg::MODE_IO_WR: begin
                     if (in_range) begin
                        unique case (port_ofs) inside
                           [epfmm_pkg::OFS_FP_FIRST:epfmm_pkg::OFS_FP_LAST]: begin
                              if (port_ofs[0]) begin
                                 fp_in[port_ofs[2:1]] = {req_data.write_data, fp_sel[7:0]};
                              end else begin
                                 fp_in[port_ofs[2:1]] = {fp_sel[15:8], req_data.write_data};
                              end
                           end
                           epfmm_pkg::OFS_EMS_LO:
                              ems_seg_in = {ems_seg_ff[15:8], req_data.write_data};
                           epfmm_pkg::OFS_EMS_HI:
                              ems_seg_in = {req_data.write_data, ems_seg_ff[7:0]};
                           epfmm_pkg::OFS_UMB_LO:
                              umb_seg_in = {umb_seg_ff[15:8], req_data.write_data};
                           epfmm_pkg::OFS_UMB_HI:
                              umb_seg_in = {req_data.write_data, umb_seg_ff[7:0]};
                           epfmm_pkg::OFS_EMS_FILL: begin
                              if (ems_fill_ok) begin
                                 fill_idx_in  = {1'b0, ems_seg_ff[15:7]};
                                 fill_left_in = {req_data.write_data, 3'd0};
                                 fill_code_in = epfmm_pkg::RG_EMS;
                                 state_in     = ST_FILL;
                              end
                           end
                           epfmm_pkg::OFS_UMB_FILL: begin
                              if (umb_fill_ok) begin
                                 fill_idx_in  = {1'b0, umb_seg_ff[15:7]};
                                 fill_left_in = {3'd0, req_data.write_data};
                                 fill_code_in = epfmm_pkg::RG_RAM;
                                 state_in     = ST_FILL;
                              end
                           end
                           default: ;
                        endcase
                     end
                  end
                  epfmm_pkg::MODE_LOOKUP: begin
                     res_in.ems_hit = frame_hit;
                     if (frame_hit) begin
                        res_in.ems_address = {fp_ff[frame_ofs[15:14]],
                                              req_data.mem_address[13:0]};
                     end
                     state_in = ST_LOOK;
                  end
                  epfmm_pkg::MODE_REBUILD: begin
                     for (int s = 0; s < 4; s++) begin
                        fp_in[s] = epfmm_pkg::FP_RST;
                     end
                     ems_seg_in   = '0;
                     umb_seg_in   = '0;
                     bld_ncm_in   = ncm_ff;
                     bld_nbr_in   = nbr_ff;
                     bld_first_in = boot_addr_ff[19:11];
                     bld_last_in  = boot_end[21:11];
                     bld_idx_in   = '0;
                     bld_item_in  = 1'b1;
                     state_in     = ST_BUILD;
                  end
                  default: ;
               endcase
            end
         end
         ST_LOOK: begin
            if (look_io_ff) begin
               res_in.read_data = 8'(map_rd_data);
            end else begin
               res_in.region = map_rd_data;
            end
            state_in = ST_PUSH;
         end
         ST_FILL: begin
            if ((fill_left_ff == 11'd0) || fill_idx_ff[AW]) begin
               state_in = ST_PUSH;
            end else begin
               fill_idx_in  = fill_idx_ff + 1'b1;
               fill_left_in = fill_left_ff - 1'b1;
            end
         end
         ST_PUSH: begin
            // output register frees up when empty or taken this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BUILD;
         for (int s = 0; s < 4; s++) begin
            fp_ff[s] <= epfmm_pkg::FP_RST;
         end
         ems_seg_ff   <= '0;
         umb_seg_ff   <= '0;
         bld_ncm_ff   <= 1'b0;
         bld_nbr_ff   <= 1'b0;
         bld_first_ff <= epfmm_pkg::BLD_FIRST_RST;
         bld_last_ff  <= epfmm_pkg::BLD_LAST_RST;
         bld_idx_ff   <= '0;
         bld_item_ff  <= 1'b0;
         fill_idx_ff  <= '0;
         fill_left_ff <= '0;
         look_io_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fp_ff        <= fp_in;
         ems_seg_ff   <= ems_seg_in;
         umb_seg_ff   <= umb_seg_in;
         bld_ncm_ff   <= bld_ncm_in;
         bld_nbr_ff   <= bld_nbr_in;
         bld_first_ff <= bld_first_in;
         bld_last_ff  <= bld_last_in;
         bld_idx_ff   <= bld_idx_in;
         bld_item_ff  <= bld_item_in;
         fill_idx_ff  <= fill_idx_in;
         fill_left_ff <= fill_left_in;
         look_io_ff   <= look_io_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fill_code_ff <= fill_code_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // configuration registers; an unknown index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         ncm_ff       <= 1'b0;
         nbr_ff       <= 1'b0;
         boot_addr_ff <= epfmm_pkg::BOOT_ADDR_RST;
         boot_size_ff <= epfmm_pkg::BOOT_SIZE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            epfmm_pkg::CSR_NO_CONV:   ncm_ff       <= csr_wdata[0];
            epfmm_pkg::CSR_NO_BOOT:   nbr_ff       <= csr_wdata[0];
            epfmm_pkg::CSR_BOOT_ADDR: boot_addr_ff <= csr_wdata[19:0];
            epfmm_pkg::CSR_BOOT_SIZE: boot_size_ff <= csr_wdata[20:0];
            default: ;
         endcase
      end
   end

`ifndef SYNTHESIS
   // the map is only written by the build and fill sweeps
   a_map_write_src: assert property (@(posedge clock) disable iff (reset)
      map_wr.en |-> (state_ff == ST_BUILD) || (state_ff == ST_FILL))
      else $error("page map written outside a sweep");

   // fill sweeps never run past the end of the map
   a_fill_in_map: assert property (@(posedge clock) disable iff (reset)
      (map_wr.en && (state_ff == ST_FILL)) |-> !fill_idx_ff[AW])
      else $error("fill write beyond last map page");

   // one item at a time: an accepted beat closes the request side
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request taken while an item is in flight");
`endif

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// EMS page-frame memory mapper testbench
// Drives I/O reads and writes, memory lookups and map rebuilds through the
// request channel and checks every response beat against an in-bench model
// of the page map, frame pointers and base segments. The boot ROM and
// conventional RAM registers are swept over several settings between phases.
// ---------------------------------------------------------------------------
module testbench;

   localparam int unsigned PORT_BASE = 608;
   localparam logic [7:0]  CSR_SPARE_FIRST = epfmm_pkg::CSR_BOOT_SIZE + 8'd1;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   epfmm_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   epfmm_pkg::rsp_type rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [7:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   ems_page_frame_memory_mapper_unit #(.PORT_BASE(PORT_BASE)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // generous wall: declares failure and stops the run if it hangs
   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Mapper model state: a private copy of the map, pointers, segments and CSRs
   // -------------------------------------------------------------------------
   logic [epfmm_pkg::CODE_W-1:0] region_map [epfmm_pkg::MAP_PAGES];
   logic [15:0]       frame_ptr [4];
   logic [15:0]       ems_seg;
   logic [15:0]       umb_seg;
   logic              cfg_no_conv;
   logic              cfg_no_boot;
   logic [19:0]       cfg_boot_addr;
   logic [20:0]       cfg_boot_size;

   epfmm_pkg::req_type pending_req [$];   // beats still to be driven
   epfmm_pkg::rsp_type expected_rsp [$];  // predicted responses, oldest first
   int unsigned issued = 0;
   int unsigned accepted = 0;
   int unsigned errors = 0;
   logic        req_fire = 1'b0;
   logic        idle_on = 1'b1;
   int          req_gap = 0;
   int          rsp_stall = 0;
   int unsigned plan_ems_seg = 0;  // stimulus-side guess of the EMS base
   epfmm_pkg::rsp_type seen_rsp;

   function automatic void fill_region(int unsigned first, int unsigned count,
                                       logic [epfmm_pkg::CODE_W-1:0] code);
      for (int unsigned i = 0; i < count && first + i < epfmm_pkg::MAP_PAGES; i++)
         region_map[first + i] = code;
   endfunction

   // Reset-time initialisation, also run by a rebuild beat. CSRs are kept.
   function automatic void rebuild_region_map();
      int unsigned first;
      int unsigned last;
      for (int unsigned i = 0; i < epfmm_pkg::MAP_PAGES; i++)
         region_map[i] = (!cfg_no_conv && i < epfmm_pkg::CONV_PAGES) ?
                         epfmm_pkg::RG_RAM : epfmm_pkg::RG_UNUSED;
      for (int i = 0; i < 4; i++)
         frame_ptr[i] = epfmm_pkg::FP_RST;
      ems_seg = '0;
      umb_seg = '0;
      if (!cfg_no_boot) begin
         first = 32'(cfg_boot_addr) >> epfmm_pkg::PAGE_SHIFT;
         last  = (32'(cfg_boot_addr) + 32'(cfg_boot_size)) >> epfmm_pkg::PAGE_SHIFT;
         for (int unsigned i = first; i < last && i < epfmm_pkg::MAP_PAGES; i++)
            region_map[i] = epfmm_pkg::RG_BOOTROM;
         // SD card page sits just past the ROM, even for a zero-length ROM
         if (last < epfmm_pkg::MAP_PAGES)
            region_map[last] = epfmm_pkg::RG_SDCARD;
      end
   endfunction

   function automatic epfmm_pkg::rsp_type predict_mapper(epfmm_pkg::req_type it);
      epfmm_pkg::rsp_type r;
      int unsigned ofs;
      int unsigned seg;
      int unsigned v;
      int unsigned base;
      int unsigned page;
      int unsigned d;
      logic [15:0] fp;
      r = '0;
      // offsets below the port base fall into the unmapped default
      ofs = (it.io_port >= PORT_BASE) ? it.io_port - PORT_BASE : 32'hFFFF_FFFF;
      v = it.write_data;
      case (it.mode)
         epfmm_pkg::MODE_IO_RD: begin
            if (ofs <= epfmm_pkg::OFS_FP_LAST) begin
               fp = frame_ptr[(ofs >> 1) & 3];
               r.read_data = (ofs & 1) ? fp[15:8] : fp[7:0];
            end else if (ofs == epfmm_pkg::OFS_UMB_FILL) begin
               r.read_data = 8'(region_map[umb_seg >> 7]);
            end else begin
               r.read_data = epfmm_pkg::BYTE_NONE;  // unmapped and write-only ports
            end
         end
         epfmm_pkg::MODE_IO_WR: begin
            if (ofs <= epfmm_pkg::OFS_FP_LAST) begin
               if (ofs & 1) frame_ptr[(ofs >> 1) & 3][15:8] = it.write_data;
               else         frame_ptr[(ofs >> 1) & 3][7:0]  = it.write_data;
            end else if (ofs == epfmm_pkg::OFS_EMS_LO) begin
               ems_seg[7:0] = it.write_data;
            end else if (ofs == epfmm_pkg::OFS_EMS_HI) begin
               ems_seg[15:8] = it.write_data;
            end else if (ofs == epfmm_pkg::OFS_EMS_FILL) begin
               seg = ems_seg;
               if (seg >= epfmm_pkg::SEG_LOW && seg + (v << 10) <= epfmm_pkg::SEG_HIGH)
                  fill_region(seg >> 7, v << 3, epfmm_pkg::RG_EMS);
            end else if (ofs == epfmm_pkg::OFS_UMB_LO) begin
               umb_seg[7:0] = it.write_data;
            end else if (ofs == epfmm_pkg::OFS_UMB_HI) begin
               umb_seg[15:8] = it.write_data;
            end else if (ofs == epfmm_pkg::OFS_UMB_FILL) begin
               seg = umb_seg;
               if (seg >= epfmm_pkg::SEG_LOW && seg + (v << 7) <= epfmm_pkg::SEG_HIGH)
                  fill_region(seg >> 7, v, epfmm_pkg::RG_RAM);
            end
         end
         epfmm_pkg::MODE_LOOKUP: begin
            r.region = region_map[it.mem_address[19:epfmm_pkg::PAGE_SHIFT]];
            base = 32'(ems_seg) << 4;
            page = 32'(it.mem_address & epfmm_pkg::FRAME_MASK);
            if (page >= base) begin
               d = page - base;
               // an unaligned EMS base never lines up with a 16 KiB frame
               if ((d & 32'h3FFF) == 0 && d <= epfmm_pkg::FRAME_OFS_MAX) begin
                  r.ems_hit = 1'b1;
                  r.ems_address = {frame_ptr[(d >> 14) & 3], it.mem_address[13:0]};
               end
            end
         end
         default: rebuild_region_map();
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t ns: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
      errors++;
   endtask

   // -------------------------------------------------------------------------
   // Monitor: check the response beat first, then predict the accepted request
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected response beat", 32'(rsp_data), '0);
         end else begin
            seen_rsp = expected_rsp.pop_front();
            if (rsp_data.read_data !== seen_rsp.read_data)
               report_mismatch("read_data", rsp_data.read_data, seen_rsp.read_data);
            if (rsp_data.region !== seen_rsp.region)
               report_mismatch("region", rsp_data.region, seen_rsp.region);
            if (rsp_data.ems_hit !== seen_rsp.ems_hit)
               report_mismatch("ems_hit", rsp_data.ems_hit, seen_rsp.ems_hit);
            if (rsp_data.ems_address !== seen_rsp.ems_address)
               report_mismatch("ems_address", rsp_data.ems_address, seen_rsp.ems_address);
         end
      end
      if (!reset && req_valid && req_ready) begin
         expected_rsp.push_back(predict_mapper(req_data));
         accepted++;
      end
      req_fire <= !reset && req_valid && req_ready;
   end

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(1, 3);
      if (pick < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // -------------------------------------------------------------------------
   // Request driver: holds a beat until taken, then idles or sends the next
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_req.size() > 0) begin
            req_data  <= pending_req.pop_front();
            req_valid <= 1'b1;
            req_gap   = (idle_on && $urandom_range(0, 1)) ? gap_len() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (idle_on && $urandom_range(0, 7) == 0)
            rsp_stall = gap_len();
      end
   end

   task automatic push_item(logic [1:0] mode, logic [15:0] port, logic [7:0] data,
                            logic [19:0] addr);
      epfmm_pkg::req_type it;
      it.mode        = mode;
      it.io_port     = port;
      it.write_data  = data;
      it.mem_address = addr;
      pending_req.push_back(it);
      issued++;
   endtask

   task automatic csr_write(logic [7:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         epfmm_pkg::CSR_NO_CONV:   cfg_no_conv   = val[0];
         epfmm_pkg::CSR_NO_BOOT:   cfg_no_boot   = val[0];
         epfmm_pkg::CSR_BOOT_ADDR: cfg_boot_addr = val[19:0];
         epfmm_pkg::CSR_BOOT_SIZE: cfg_boot_size = val[20:0];
         default: ;  // spare index, dropped
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (accepted != issued || expected_rsp.size() != 0) @(posedge clock);
   endtask

   // Random traffic: mostly well-formed set-up sequences, plus noise
   task automatic gen_traffic(int unsigned n);
      int unsigned target;
      int unsigned pick;
      int unsigned seg;
      int unsigned maxv;
      int unsigned v;
      int unsigned ofs;
      logic [19:0] addr;
      target = issued + n;
      while (issued < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            // EMS base, some frame pointer bytes, then a window fill
            seg = $urandom_range(16'hA000, 16'hF000);
            if ($urandom_range(0, 3) != 0) seg &= 32'hFC00;
            if ($urandom_range(0, 7) == 0) seg = $urandom_range(0, 16'hFFFF);
            push_item(epfmm_pkg::MODE_IO_WR, PORT_BASE + epfmm_pkg::OFS_EMS_LO, seg[7:0],
                      20'($urandom));
            push_item(epfmm_pkg::MODE_IO_WR, PORT_BASE + epfmm_pkg::OFS_EMS_HI, seg[15:8],
                      20'($urandom));
            plan_ems_seg = seg;
            repeat ($urandom_range(1, 4)) begin
               ofs = $urandom_range(epfmm_pkg::OFS_FP_FIRST, epfmm_pkg::OFS_FP_LAST);
               push_item(epfmm_pkg::MODE_IO_WR, PORT_BASE + ofs, 8'($urandom),
                         20'($urandom));
            end
            maxv = (seg >= epfmm_pkg::SEG_LOW && seg <= epfmm_pkg::SEG_HIGH) ?
                   (epfmm_pkg::SEG_HIGH - seg) >> 10 : 4;
            v = ($urandom_range(0, 5) != 0) ? $urandom_range(0, maxv) : $urandom_range(0, 255);
            push_item(epfmm_pkg::MODE_IO_WR, PORT_BASE + epfmm_pkg::OFS_EMS_FILL, v[7:0],
                      20'($urandom));
         end else if (pick < 35) begin
            // UMB base, a RAM fill, then read back the region at the base
            seg = $urandom_range(16'hA000, 16'hF000);
            if ($urandom_range(0, 7) == 0) seg = $urandom_range(0, 16'hFFFF);
            push_item(epfmm_pkg::MODE_IO_WR, PORT_BASE + epfmm_pkg::OFS_UMB_LO, seg[7:0],
                      20'($urandom));
            push_item(epfmm_pkg::MODE_IO_WR, PORT_BASE + epfmm_pkg::OFS_UMB_HI, seg[15:8],
                      20'($urandom));
            maxv = (seg >= epfmm_pkg::SEG_LOW && seg <= epfmm_pkg::SEG_HIGH) ?
                   (epfmm_pkg::SEG_HIGH - seg) >> 7 : 4;
            if (maxv > 255) maxv = 255;
            v = ($urandom_range(0, 5) != 0) ? $urandom_range(0, maxv) : $urandom_range(0, 255);
            push_item(epfmm_pkg::MODE_IO_WR, PORT_BASE + epfmm_pkg::OFS_UMB_FILL, v[7:0],
                      20'($urandom));
            push_item(epfmm_pkg::MODE_IO_RD, PORT_BASE + epfmm_pkg::OFS_UMB_FILL, 8'($urandom),
                      20'($urandom));
         end else if (pick < 70) begin
            // lookups, mostly around the current EMS window
            if ($urandom_range(0, 3) != 0)
               addr = 20'((plan_ems_seg << 4) + $urandom_range(0, 16'hFFFF));
            else
               addr = 20'($urandom);
            push_item(epfmm_pkg::MODE_LOOKUP, 16'($urandom), 8'($urandom), addr);
         end else if (pick < 85) begin
            ofs = ($urandom_range(0, 3) != 0) ? PORT_BASE + $urandom_range(0, 15)
                                               : $urandom_range(0, 16'hFFFF);
            push_item(epfmm_pkg::MODE_IO_RD, ofs[15:0], 8'($urandom), 20'($urandom));
         end else if (pick < 97) begin
            ofs = ($urandom_range(0, 3) != 0) ? PORT_BASE + $urandom_range(0, 15)
                                               : $urandom_range(0, 16'hFFFF);
            push_item(epfmm_pkg::MODE_IO_WR, ofs[15:0], 8'($urandom), 20'($urandom));
         end else begin
            push_item(epfmm_pkg::MODE_REBUILD, 16'($urandom), 8'($urandom), 20'($urandom));
            plan_ems_seg = 0;
         end
      end
   endtask

   // one configuration setting: write every CSR, rebuild, then random traffic
   task automatic run_phase(logic [31:0] no_conv, logic [31:0] no_boot,
                            logic [31:0] boot_addr, logic [31:0] boot_size,
                            int unsigned n, logic idle);
      idle_on = idle;
      csr_write(epfmm_pkg::CSR_NO_CONV, no_conv);
      csr_write(epfmm_pkg::CSR_NO_BOOT, no_boot);
      csr_write(epfmm_pkg::CSR_BOOT_ADDR, boot_addr);
      csr_write(epfmm_pkg::CSR_BOOT_SIZE, boot_size);
      csr_write(8'($urandom_range(CSR_SPARE_FIRST, 8'hFF)), $urandom);
      push_item(epfmm_pkg::MODE_REBUILD, 16'($urandom), 8'($urandom), 20'($urandom));
      plan_ems_seg = 0;
      gen_traffic(n);
      wait_drained();
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      cfg_no_conv   = 1'b0;
      cfg_no_boot   = 1'b0;
      cfg_boot_addr = epfmm_pkg::BOOT_ADDR_RST;
      cfg_boot_size = epfmm_pkg::BOOT_SIZE_RST;
      rebuild_region_map();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed beats on the reset configuration
      push_item(epfmm_pkg::MODE_REBUILD, '0, '0, '0);
      push_item(epfmm_pkg::MODE_IO_RD, PORT_BASE + epfmm_pkg::OFS_FP_FIRST, '0, '0);
      push_item(epfmm_pkg::MODE_IO_RD, PORT_BASE + epfmm_pkg::OFS_FP_LAST, '0, '0);
      push_item(epfmm_pkg::MODE_IO_RD, PORT_BASE + epfmm_pkg::OFS_UMB_FILL, '0, '0);
      push_item(epfmm_pkg::MODE_IO_RD, PORT_BASE + epfmm_pkg::OFS_EMS_LO, '0, '0);
      push_item(epfmm_pkg::MODE_IO_RD, 16'h0000, 8'hFF, 20'hFFFFF);
      push_item(epfmm_pkg::MODE_IO_RD, 16'hFFFF, '0, '0);
      push_item(epfmm_pkg::MODE_IO_WR, PORT_BASE + epfmm_pkg::OFS_FP_FIRST, 8'h12, '0);
      push_item(epfmm_pkg::MODE_IO_WR, PORT_BASE + epfmm_pkg::OFS_FP_FIRST + 1, 8'h34, '0);
      push_item(epfmm_pkg::MODE_IO_WR, PORT_BASE + epfmm_pkg::OFS_FP_LAST, 8'h00, '0);
      push_item(epfmm_pkg::MODE_IO_WR, PORT_BASE + epfmm_pkg::OFS_FP_LAST - 1, 8'hFF, '0);
      push_item(epfmm_pkg::MODE_IO_WR, PORT_BASE + epfmm_pkg::OFS_EMS_LO, 8'h00, '0);
      push_item(epfmm_pkg::MODE_IO_WR, PORT_BASE + epfmm_pkg::OFS_EMS_HI, 8'hD0, '0);
      push_item(epfmm_pkg::MODE_IO_WR, PORT_BASE + epfmm_pkg::OFS_EMS_FILL, 8'd4, '0);
      push_item(epfmm_pkg::MODE_LOOKUP, '0, '0, 20'hD0000);      // frame 0
      push_item(epfmm_pkg::MODE_LOOKUP, '0, '0, 20'hDC123);      // frame 3
      push_item(epfmm_pkg::MODE_LOOKUP, '0, '0, 20'hE0000);      // just past the frames
      push_item(epfmm_pkg::MODE_LOOKUP, 16'hFFFF, 8'hFF, 20'h00000);
      push_item(epfmm_pkg::MODE_LOOKUP, '0, '0, 20'hFFFFF);
      push_item(epfmm_pkg::MODE_IO_WR, PORT_BASE + epfmm_pkg::OFS_UMB_LO, 8'h00, '0);
      push_item(epfmm_pkg::MODE_IO_WR, PORT_BASE + epfmm_pkg::OFS_UMB_HI, 8'hC8, '0);
      // one over the top, then one that ends right on it
      push_item(epfmm_pkg::MODE_IO_WR, PORT_BASE + epfmm_pkg::OFS_UMB_FILL, 8'h51, '0);
      push_item(epfmm_pkg::MODE_IO_WR, PORT_BASE + epfmm_pkg::OFS_UMB_FILL, 8'h50, '0);
      push_item(epfmm_pkg::MODE_IO_RD, PORT_BASE + epfmm_pkg::OFS_UMB_FILL, '0, '0);
      // unmapped port
      push_item(epfmm_pkg::MODE_IO_WR, PORT_BASE + epfmm_pkg::OFS_FP_LAST + 1, 8'hFF, '0);
      // unaligned base
      push_item(epfmm_pkg::MODE_IO_WR, PORT_BASE + epfmm_pkg::OFS_EMS_LO, 8'h10, '0);
      push_item(epfmm_pkg::MODE_LOOKUP, '0, '0, 20'hD4000);
      // base below the window
      push_item(epfmm_pkg::MODE_IO_WR, PORT_BASE + epfmm_pkg::OFS_EMS_HI, 8'h90, '0);
      push_item(epfmm_pkg::MODE_IO_WR, PORT_BASE + epfmm_pkg::OFS_EMS_FILL, 8'd1, '0);
      wait_drained();

      run_phase(0, 0, epfmm_pkg::BOOT_ADDR_RST, epfmm_pkg::BOOT_SIZE_RST, 44, 1'b1);
      run_phase(1, 1, 32'h000C0000, 32'h00010000, 44, 1'b0);
      run_phase(0, 0, 32'h00000000, 32'h00000000, 44, 1'b1);
      run_phase(1, 0, 32'h000FFFFF, 32'h00100000, 44, 1'b1);
      run_phase(32'hFFFFFFFE, 32'hFFFFFFFE, 32'hFFFFFFFF, 32'hFFFFFFFF, 44, 1'b1);
      run_phase(0, 0, 32'h000A0000, 32'h00000800, 44, 1'b0);
      repeat (3)
         run_phase($urandom, $urandom, $urandom,
                   ($urandom_range(0, 3) != 0) ? $urandom_range(0, 32'h10000) : $urandom,
                   44, 1'b1);

      // nothing in flight now; a short tail catches any stray beat
      repeat (20) @(posedge clock);
      if (expected_rsp.size() != 0)
         report_mismatch("leftover expectations", expected_rsp.size(), 0);
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
